@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers for the trial generator rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define DTVG_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// next-cycle implication, off while reset is high
`define DTVG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`endif

@@ hw/rtl/dtvg_pkg.sv @@
// ----------------------------------------------------------------------------
// dtvg_pkg
// shared widths, codes, reset values and bundle types of the trial generator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtvg_pkg;

   // sizing
   localparam int MAX_PARAMS     = 16;
   localparam int MAX_POPULATION = 256;
   localparam int VALUE_W        = 32;
   localparam int FRAC_W         = 16;
   localparam int DRAW_W         = 32;
   localparam int WEIGHT_W       = 18;
   localparam int CUR_W          = 8;
   localparam int PART_W         = 8;
   localparam int MODE_W         = 2;
   localparam int ECNT_W         = $clog2(MAX_PARAMS);
   localparam int NPARAM_W       = $clog2(MAX_PARAMS + 1);
   localparam int PIDX_W         = $clog2(MAX_POPULATION);
   localparam int POP_W          = $clog2(MAX_POPULATION + 1);
   localparam int MUL_W          = VALUE_W + 1;
   localparam int PROD_W         = 2 * MUL_W;
   localparam int SUM_W          = PROD_W - FRAC_W + 1;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;

   // generator constants
   localparam logic [DRAW_W-1:0] RNG_INCR = 32'h6D2B79F5;
   localparam logic [DRAW_W-1:0] MIX_OR   = 32'd61;

   // input modes
   localparam logic [MODE_W-1:0] MODE_GEN      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PARTNERS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TRIAL    = 2'd2;
   localparam logic [MODE_W-1:0] MODE_INIT     = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SEED       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DITHER     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_FIX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WEIGHT_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_POP_SIZE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_PARAMS = 3'd7;

   // reset values
   localparam logic [DRAW_W-1:0]   SEED_RST       = 32'd0;
   localparam logic                DITHER_RST     = 1'b1;
   localparam logic [WEIGHT_W-1:0] WEIGHT_FIX_RST = 18'd32768;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MIN_RST = 18'd32768;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX_RST = 18'd65536;
   localparam logic [DRAW_W-1:0]   THRESHOLD_RST  = 32'd3865470566;
   localparam logic [POP_W-1:0]    POP_RST        = 9'd64;
   localparam logic [NPARAM_W-1:0] NPARAM_RST     = 5'd4;
   localparam logic [POP_W-1:0]    POP_MIN        = POP_W'(4);
   localparam logic [POP_W-1:0]    POP_MAX        = POP_W'(MAX_POPULATION);
   localparam logic [NPARAM_W-1:0] NPARAM_MIN     = NPARAM_W'(1);
   localparam logic [NPARAM_W-1:0] NPARAM_MAX     = NPARAM_W'(MAX_PARAMS);

   typedef struct packed {
      logic                seed_load;
      logic [DRAW_W-1:0]   seed_value;
      logic                dither_enable;
      logic [WEIGHT_W-1:0] weight_fixed;
      logic [WEIGHT_W-1:0] weight_min;
      logic [WEIGHT_W-1:0] weight_max;
      logic [DRAW_W-1:0]   threshold;
      logic [POP_W-1:0]    pop_size;
      logic [NPARAM_W-1:0] num_params;
   } cfg_type;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic [CUR_W-1:0]          current_index;
      logic                      first_element;
      logic                      last_element;
      logic signed [VALUE_W-1:0] self_value;
      logic signed [VALUE_W-1:0] a_value;
      logic signed [VALUE_W-1:0] b_value;
      logic signed [VALUE_W-1:0] c_value;
      logic signed [VALUE_W-1:0] low_value;
      logic signed [VALUE_W-1:0] high_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value_out;
      logic [PART_W-1:0]         partner_a;
      logic [PART_W-1:0]         partner_b;
      logic [PART_W-1:0]         partner_c;
      logic                      vector_done;
   } result_type;

   typedef struct packed {
      logic idle;
      logic res_valid;
   } core_status_type;

endpackage

@@ hw/rtl/dtvg_mul.sv @@
// ----------------------------------------------------------------------------
// dtvg_mul
// shared signed multiplier with a registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtvg_mul (
   input  logic                                clock,
   input  logic                                mul_en,
   input  logic signed [dtvg_pkg::MUL_W-1:0]   op_a,
   input  logic signed [dtvg_pkg::MUL_W-1:0]   op_b,
   output logic signed [dtvg_pkg::PROD_W-1:0]  prod
);

   logic signed [dtvg_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= op_a * op_b;
      end
   end

   assign prod = prod_ff;

endmodule

@@ hw/rtl/dtvg_csr.sv @@
// ----------------------------------------------------------------------------
// dtvg_csr
// configuration registers with range limiting on population and vector length
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtvg_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [dtvg_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [dtvg_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output dtvg_pkg::cfg_type                    cfg
);

   logic                                dither_ff, dither_in;
   logic [dtvg_pkg::WEIGHT_W-1:0]       wfix_ff, wfix_in;
   logic [dtvg_pkg::WEIGHT_W-1:0]       wmin_ff, wmin_in;
   logic [dtvg_pkg::WEIGHT_W-1:0]       wmax_ff, wmax_in;
   logic [dtvg_pkg::DRAW_W-1:0]         thr_ff, thr_in;
   logic [dtvg_pkg::POP_W-1:0]          pop_ff, pop_in;
   logic [dtvg_pkg::NPARAM_W-1:0]       npar_ff, npar_in;
   logic [dtvg_pkg::POP_W-1:0]          pop_raw;
   logic [dtvg_pkg::NPARAM_W-1:0]       npar_raw;
   logic [dtvg_pkg::POP_W-1:0]          pop_lim;
   logic [dtvg_pkg::NPARAM_W-1:0]       npar_lim;

   assign pop_raw  = csr_wdata[dtvg_pkg::POP_W-1:0];
   assign npar_raw = csr_wdata[dtvg_pkg::NPARAM_W-1:0];

   // limit to the supported ranges on the way in
   always_comb begin
      pop_lim = pop_raw;
      if (pop_raw < dtvg_pkg::POP_MIN) begin
         pop_lim = dtvg_pkg::POP_MIN;
      end else if (pop_raw > dtvg_pkg::POP_MAX) begin
         pop_lim = dtvg_pkg::POP_MAX;
      end
      npar_lim = npar_raw;
      if (npar_raw < dtvg_pkg::NPARAM_MIN) begin
         npar_lim = dtvg_pkg::NPARAM_MIN;
      end else if (npar_raw > dtvg_pkg::NPARAM_MAX) begin
         npar_lim = dtvg_pkg::NPARAM_MAX;
      end
   end

   always_comb begin
      dither_in = dither_ff;
      wfix_in   = wfix_ff;
      wmin_in   = wmin_ff;
      wmax_in   = wmax_ff;
      thr_in    = thr_ff;
      pop_in    = pop_ff;
      npar_in   = npar_ff;
      if (csr_we) begin
         unique case (csr_index)
            dtvg_pkg::CSR_DITHER:     dither_in = csr_wdata[0];
            dtvg_pkg::CSR_WEIGHT_FIX: wfix_in   = csr_wdata[dtvg_pkg::WEIGHT_W-1:0];
            dtvg_pkg::CSR_WEIGHT_MIN: wmin_in   = csr_wdata[dtvg_pkg::WEIGHT_W-1:0];
            dtvg_pkg::CSR_WEIGHT_MAX: wmax_in   = csr_wdata[dtvg_pkg::WEIGHT_W-1:0];
            dtvg_pkg::CSR_THRESHOLD:  thr_in    = csr_wdata[dtvg_pkg::DRAW_W-1:0];
            dtvg_pkg::CSR_POP_SIZE:   pop_in    = pop_lim;
            dtvg_pkg::CSR_NUM_PARAMS: npar_in   = npar_lim;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dither_ff <= dtvg_pkg::DITHER_RST;
         wfix_ff   <= dtvg_pkg::WEIGHT_FIX_RST;
         wmin_ff   <= dtvg_pkg::WEIGHT_MIN_RST;
         wmax_ff   <= dtvg_pkg::WEIGHT_MAX_RST;
         thr_ff    <= dtvg_pkg::THRESHOLD_RST;
         pop_ff    <= dtvg_pkg::POP_RST;
         npar_ff   <= dtvg_pkg::NPARAM_RST;
      end else begin
         dither_ff <= dither_in;
         wfix_ff   <= wfix_in;
         wmin_ff   <= wmin_in;
         wmax_ff   <= wmax_in;
         thr_ff    <= thr_in;
         pop_ff    <= pop_in;
         npar_ff   <= npar_in;
      end
   end

   // the seed is not kept: a write reloads the generator directly, and is lost unless the core is idle
   always_comb begin
      cfg.seed_load     = csr_we && (csr_index == dtvg_pkg::CSR_SEED);
      cfg.seed_value    = csr_wdata[dtvg_pkg::DRAW_W-1:0];
      cfg.dither_enable = dither_ff;
      cfg.weight_fixed  = wfix_ff;
      cfg.weight_min    = wmin_ff;
      cfg.weight_max    = wmax_ff;
      cfg.threshold     = thr_ff;
      cfg.pop_size      = pop_ff;
      cfg.num_params    = npar_ff;
   end

endmodule

@@ hw/rtl/dtvg_core.sv @@
// ----------------------------------------------------------------------------
// dtvg_core
// sequencer and datapath: random draws, scaling, partner picks and crossover
// all products go through one shared multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dtvg_core (
   input  logic                        clock,
   input  logic                        reset,
   input  dtvg_pkg::cfg_type           cfg,
   input  logic                        req_valid,
   input  dtvg_pkg::req_type           req,
   input  logic                        out_ready,
   output dtvg_pkg::core_status_type   status,
   output dtvg_pkg::result_type        result
);

   localparam int ST_W  = 4;
   localparam int JOB_W = 3;
   localparam int K_W   = 2;

   localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
   localparam logic [ST_W-1:0] S_INC    = 4'd1;
   localparam logic [ST_W-1:0] S_MIX1   = 4'd2;
   localparam logic [ST_W-1:0] S_MIX2   = 4'd3;
   localparam logic [ST_W-1:0] S_MIX3   = 4'd4;
   localparam logic [ST_W-1:0] S_XOVER  = 4'd5;
   localparam logic [ST_W-1:0] S_SCALE  = 4'd6;
   localparam logic [ST_W-1:0] S_APPLY  = 4'd7;
   localparam logic [ST_W-1:0] S_RESULT = 4'd8;

   localparam logic [JOB_W-1:0] JOB_WEIGHT = 3'd0;
   localparam logic [JOB_W-1:0] JOB_PICK   = 3'd1;
   localparam logic [JOB_W-1:0] JOB_FORCED = 3'd2;
   localparam logic [JOB_W-1:0] JOB_XOVER  = 3'd3;
   localparam logic [JOB_W-1:0] JOB_TRIAL  = 3'd4;
   localparam logic [JOB_W-1:0] JOB_INIT   = 3'd5;

   localparam logic [K_W-1:0] PICK_FIRST  = 2'd0;
   localparam logic [K_W-1:0] PICK_SECOND = 2'd1;
   localparam logic [K_W-1:0] PICK_LAST   = 2'd2;

   logic [ST_W-1:0]                        state_ff, state_in;
   logic [JOB_W-1:0]                       job_ff, job_in;
   logic [dtvg_pkg::DRAW_W-1:0]            rng_ff, rng_in;
   logic [dtvg_pkg::DRAW_W-1:0]            t_ff, t_in;
   logic [dtvg_pkg::DRAW_W-1:0]            r_ff, r_in;
   logic signed [dtvg_pkg::MUL_W-1:0]      diff_ff, diff_in;
   logic signed [dtvg_pkg::VALUE_W-1:0]    base_ff, base_in;
   logic signed [dtvg_pkg::VALUE_W-1:0]    lo_ff, lo_in;
   logic signed [dtvg_pkg::VALUE_W-1:0]    hi_ff, hi_in;
   logic signed [dtvg_pkg::VALUE_W-1:0]    self_ff, self_in;
   logic [dtvg_pkg::CUR_W-1:0]             cur_ff, cur_in;
   logic [dtvg_pkg::MODE_W-1:0]            mode_ff, mode_in;
   logic                                   last_ff, last_in;
   logic                                   clamp_ff, clamp_in;
   logic [K_W-1:0]                         k_ff, k_in;
   logic [dtvg_pkg::PIDX_W-1:0]            pa_ff, pa_in;
   logic [dtvg_pkg::PIDX_W-1:0]            pb_ff, pb_in;
   logic [dtvg_pkg::PIDX_W-1:0]            pc_ff, pc_in;
   logic signed [dtvg_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [dtvg_pkg::WEIGHT_W-1:0]          weight_ff, weight_in;
   logic [dtvg_pkg::ECNT_W-1:0]            forced_ff, forced_in;
   logic [dtvg_pkg::ECNT_W-1:0]            ecount_ff, ecount_in;

   logic                                   mul_en;
   logic signed [dtvg_pkg::MUL_W-1:0]      mul_a;
   logic signed [dtvg_pkg::MUL_W-1:0]      mul_b;
   logic signed [dtvg_pkg::PROD_W-1:0]     prod;

   logic                                   req_xfer;
   logic [dtvg_pkg::DRAW_W-1:0]            t1;
   logic [dtvg_pkg::DRAW_W-1:0]            t2;
   logic [dtvg_pkg::PIDX_W-1:0]            idx;
   logic                                   hit;
   logic signed [dtvg_pkg::SUM_W-1:0]      lo_ext;
   logic signed [dtvg_pkg::SUM_W-1:0]      hi_ext;
   logic signed [dtvg_pkg::SUM_W-1:0]      val;

   dtvg_mul u_mul (
      .clock  (clock),
      .mul_en (mul_en),
      .op_a   (mul_a),
      .op_b   (mul_b),
      .prod   (prod)
   );

   assign req_xfer = req_valid && (state_ff == S_IDLE);
   assign t1       = prod[dtvg_pkg::DRAW_W-1:0];
   assign t2       = (prod[dtvg_pkg::DRAW_W-1:0] + t_ff) ^ t_ff;
   assign idx      = prod[dtvg_pkg::DRAW_W +: dtvg_pkg::PIDX_W];

   // rejection against the current index and the partners already taken
   assign hit = (idx == cur_ff)
             || ((k_ff != PICK_FIRST) && (idx == pa_ff))
             || ((k_ff == PICK_LAST) && (idx == pb_ff));

   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      rng_in    = rng_ff;
      t_in      = t_ff;
      r_in      = r_ff;
      diff_in   = diff_ff;
      base_in   = base_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      self_in   = self_ff;
      cur_in    = cur_ff;
      mode_in   = mode_ff;
      last_in   = last_ff;
      clamp_in  = clamp_ff;
      k_in      = k_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      pc_in     = pc_ff;
      sum_in    = sum_ff;
      weight_in = weight_ff;
      forced_in = forced_ff;
      ecount_in = ecount_ff;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cfg.seed_load) begin
               rng_in = cfg.seed_value;
            end
            if (req_valid) begin
               mode_in  = req.mode;
               cur_in   = req.current_index;
               last_in  = req.last_element;
               self_in  = req.self_value;
               lo_in    = req.low_value;
               hi_in    = req.high_value;
               base_in  = (req.mode == dtvg_pkg::MODE_INIT) ? req.low_value : req.c_value;
               clamp_in = 1'b0;
               k_in     = PICK_FIRST;
               state_in = S_INC;
               unique case (req.mode)
                  dtvg_pkg::MODE_GEN: begin
                     diff_in   = dtvg_pkg::MUL_W'(cfg.weight_max)
                               - dtvg_pkg::MUL_W'(cfg.weight_min);
                     ecount_in = '0;
                     job_in    = JOB_WEIGHT;
                     if (!cfg.dither_enable) begin
                        weight_in = cfg.weight_fixed;
                        state_in  = S_RESULT;
                     end
                  end
                  dtvg_pkg::MODE_PARTNERS: begin
                     job_in = JOB_PICK;
                  end
                  dtvg_pkg::MODE_TRIAL: begin
                     diff_in = dtvg_pkg::MUL_W'(req.b_value) - dtvg_pkg::MUL_W'(req.a_value);
                     job_in  = req.first_element ? JOB_FORCED : JOB_XOVER;
                  end
                  dtvg_pkg::MODE_INIT: begin
                     diff_in = dtvg_pkg::MUL_W'(req.high_value)
                             - dtvg_pkg::MUL_W'(req.low_value);
                     job_in  = JOB_INIT;
                  end
               endcase
            end
         end
         S_INC: begin
            rng_in   = rng_ff + dtvg_pkg::RNG_INCR;
            state_in = S_MIX1;
         end
         S_MIX1: begin
            mul_en   = 1'b1;
            mul_a    = {1'b0, rng_ff ^ (rng_ff >> 15)};
            mul_b    = {1'b0, rng_ff | dtvg_pkg::DRAW_W'(1)};
            state_in = S_MIX2;
         end
         S_MIX2: begin
            mul_en   = 1'b1;
            t_in     = t1;
            mul_a    = {1'b0, t1 ^ (t1 >> 7)};
            mul_b    = {1'b0, t1 | dtvg_pkg::MIX_OR};
            state_in = S_MIX3;
         end
         S_MIX3: begin
            r_in     = t2 ^ (t2 >> 14);
            state_in = (job_ff == JOB_XOVER) ? S_XOVER : S_SCALE;
         end
         S_XOVER: begin
            if ((ecount_ff == forced_ff) || (r_ff < cfg.threshold)) begin
               job_in   = JOB_TRIAL;
               clamp_in = 1'b1;
               state_in = S_SCALE;
            end else begin
               sum_in   = dtvg_pkg::SUM_W'(self_ff);
               state_in = S_RESULT;
            end
         end
         S_SCALE: begin
            mul_en   = 1'b1;
            state_in = S_APPLY;
            unique case (job_ff)
               JOB_WEIGHT, JOB_INIT: begin
                  mul_a = diff_ff;
                  mul_b = {1'b0, r_ff};
               end
               JOB_TRIAL: begin
                  mul_a = diff_ff;
                  mul_b = dtvg_pkg::MUL_W'(weight_ff);
               end
               JOB_PICK: begin
                  mul_a = {1'b0, r_ff};
                  mul_b = dtvg_pkg::MUL_W'(cfg.pop_size);
               end
               JOB_FORCED: begin
                  mul_a = {1'b0, r_ff};
                  mul_b = dtvg_pkg::MUL_W'(cfg.num_params);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         S_APPLY: begin
            state_in = S_RESULT;
            unique case (job_ff)
               JOB_WEIGHT: begin
                  weight_in = cfg.weight_min + prod[dtvg_pkg::DRAW_W +: dtvg_pkg::WEIGHT_W];
               end
               JOB_PICK: begin
                  if (hit) begin
                     state_in = S_INC;
                  end else begin
                     case (k_ff)
                        PICK_FIRST:  pa_in = idx;
                        PICK_SECOND: pb_in = idx;
                        default:     pc_in = idx;
                     endcase
                     if (k_ff != PICK_LAST) begin
                        k_in     = k_ff + K_W'(1);
                        state_in = S_INC;
                     end
                  end
               end
               JOB_FORCED: begin
                  forced_in = prod[dtvg_pkg::DRAW_W +: dtvg_pkg::ECNT_W];
                  ecount_in = '0;
                  job_in    = JOB_XOVER;
                  state_in  = S_INC;
               end
               JOB_TRIAL: begin
                  sum_in = dtvg_pkg::SUM_W'(base_ff)
                         + dtvg_pkg::SUM_W'($signed(prod[dtvg_pkg::PROD_W-1:dtvg_pkg::FRAC_W]));
               end
               JOB_INIT: begin
                  sum_in = dtvg_pkg::SUM_W'(base_ff)
                         + dtvg_pkg::SUM_W'($signed(prod[dtvg_pkg::PROD_W-1:dtvg_pkg::DRAW_W]));
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RESULT: begin
            if (out_ready) begin
               state_in = S_IDLE;
               if (mode_ff == dtvg_pkg::MODE_TRIAL) begin
                  if (last_ff || (ecount_ff == dtvg_pkg::ECNT_W'(dtvg_pkg::MAX_PARAMS - 1))) begin
                     ecount_in = '0;
                  end else begin
                     ecount_in = ecount_ff + dtvg_pkg::ECNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rng_ff    <= dtvg_pkg::SEED_RST;
         weight_ff <= dtvg_pkg::WEIGHT_FIX_RST;
         forced_ff <= '0;
         ecount_ff <= '0;
      end else begin
         state_ff  <= state_in;
         rng_ff    <= rng_in;
         weight_ff <= weight_in;
         forced_ff <= forced_in;
         ecount_ff <= ecount_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      t_ff     <= t_in;
      r_ff     <= r_in;
      diff_ff  <= diff_in;
      base_ff  <= base_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      self_ff  <= self_in;
      cur_ff   <= cur_in;
      mode_ff  <= mode_in;
      last_ff  <= last_in;
      clamp_ff <= clamp_in;
      k_ff     <= k_in;
      pa_ff    <= pa_in;
      pb_ff    <= pb_in;
      pc_ff    <= pc_in;
      sum_ff   <= sum_in;
   end

   // lower limit first, then upper, so a reversed pair ends at the upper one
   assign lo_ext = dtvg_pkg::SUM_W'(lo_ff);
   assign hi_ext = dtvg_pkg::SUM_W'(hi_ff);

   always_comb begin
      val = sum_ff;
      if (clamp_ff) begin
         if (val < lo_ext) begin
            val = lo_ext;
         end
         if (val > hi_ext) begin
            val = hi_ext;
         end
      end
   end

   always_comb begin
      result = '0;
      unique case (mode_ff) inside
         dtvg_pkg::MODE_TRIAL, dtvg_pkg::MODE_INIT: begin
            result.value_out   = val[dtvg_pkg::VALUE_W-1:0];
            result.vector_done = last_ff;
         end
         dtvg_pkg::MODE_PARTNERS: begin
            result.partner_a = dtvg_pkg::PART_W'(pa_ff);
            result.partner_b = dtvg_pkg::PART_W'(pb_ff);
            result.partner_c = dtvg_pkg::PART_W'(pc_ff);
         end
         default: begin
         end
      endcase
   end

   assign status.idle      = (state_ff == S_IDLE);
   assign status.res_valid = (state_ff == S_RESULT);

   `DTVG_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, state_ff != S_IDLE)
   `DTVG_ASSERT_IMPLY(a_pick_in_range, clock, reset, (state_ff == S_APPLY) && (job_ff == JOB_PICK), prod[dtvg_pkg::DRAW_W +: dtvg_pkg::POP_W] < cfg.pop_size)
   `DTVG_ASSERT_IMPLY(a_partners_distinct, clock, reset, status.res_valid && (mode_ff == dtvg_pkg::MODE_PARTNERS), (pa_ff != pb_ff) && (pa_ff != pc_ff) && (pb_ff != pc_ff))
   `DTVG_ASSERT_IMPLY(a_partners_not_self, clock, reset, status.res_valid && (mode_ff == dtvg_pkg::MODE_PARTNERS), (pa_ff != cur_ff) && (pb_ff != cur_ff) && (pc_ff != cur_ff))

endmodule

@@ hw/rtl/de_trial_vector_generator.sv @@
// ----------------------------------------------------------------------------
// de_trial_vector_generator
// differential-evolution rand/1/bin trial generator with a mulberry32 source
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall mode, index, element marks, six values
//   rsp      out  rsp_valid/rsp_stall value_out, partner_a/b/c, vector_done
//   csr      in   csr_we              csr_index, csr_wdata
//
// one item at a time; a draw passes inc and mix1 to mix3, a scaling product
// scale and apply, all on one shared 33x33 multiplier. generation: fixed
// weight, or a draw and a product; trial: a draw, a product on crossover,
// plus both on a first element; init: both; partners: both per pick or retry
// reset is synchronous; the generator state starts from a zero seed
// a finished result waits in the output register while the next item starts
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module de_trial_vector_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [dtvg_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dtvg_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [dtvg_pkg::MODE_W-1:0]           req_mode,
   input  logic [dtvg_pkg::CUR_W-1:0]            req_current_index,
   input  logic                                  req_first_element,
   input  logic                                  req_last_element,
   input  logic signed [dtvg_pkg::VALUE_W-1:0]   req_self_value,
   input  logic signed [dtvg_pkg::VALUE_W-1:0]   req_a_value,
   input  logic signed [dtvg_pkg::VALUE_W-1:0]   req_b_value,
   input  logic signed [dtvg_pkg::VALUE_W-1:0]   req_c_value,
   input  logic signed [dtvg_pkg::VALUE_W-1:0]   req_low_value,
   input  logic signed [dtvg_pkg::VALUE_W-1:0]   req_high_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [dtvg_pkg::VALUE_W-1:0]   rsp_value_out,
   output logic [dtvg_pkg::PART_W-1:0]           rsp_partner_a,
   output logic [dtvg_pkg::PART_W-1:0]           rsp_partner_b,
   output logic [dtvg_pkg::PART_W-1:0]           rsp_partner_c,
   output logic                                  rsp_vector_done
);

   dtvg_pkg::cfg_type           cfg;
   dtvg_pkg::req_type           req;
   dtvg_pkg::result_type        result;
   dtvg_pkg::core_status_type   status;
   dtvg_pkg::result_type        rsp_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        out_ready;
   logic                        out_load;

   always_comb begin
      req.mode          = req_mode;
      req.current_index = req_current_index;
      req.first_element = req_first_element;
      req.last_element  = req_last_element;
      req.self_value    = req_self_value;
      req.a_value       = req_a_value;
      req.b_value       = req_b_value;
      req.c_value       = req_c_value;
      req.low_value     = req_low_value;
      req.high_value    = req_high_value;
   end

   dtvg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dtvg_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req       (req),
      .out_ready (out_ready),
      .status    (status),
      .result    (result)
   );

   // output register frees up on the same cycle its transfer completes
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign out_load  = status.res_valid && out_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_ff <= result;
      end
   end

   assign req_stall       = !status.idle;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_out   = rsp_ff.value_out;
   assign rsp_partner_a   = rsp_ff.partner_a;
   assign rsp_partner_b   = rsp_ff.partner_b;
   assign rsp_partner_c   = rsp_ff.partner_c;
   assign rsp_vector_done = rsp_ff.vector_done;

endmodule
